>>> src/ploc_pkg.sv
`timescale 1ns / 1ps

package ploc_pkg;

    // Character codes the compositor reacts to
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_USCORE = 8'h5F;

    // Counter limits and reset values
    localparam logic [15:0] COL_MAX     = 16'hFFFF;
    localparam logic [15:0] PAGE_MAX    = 16'hFFFF;
    localparam logic [15:0] PAGE_RESET  = 16'd1;
    localparam logic [1:0]  BLANK_LIMIT = 2'd3;
    localparam logic [7:0]  LPP_RESET   = 8'd63;

    // Register map
    localparam int         APB_AW  = 3;
    localparam logic [0:0] REG_LPP = 1'b0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHAR,
        S_END,
        S_LINE,
        S_CR,
        S_UL,
        S_TERM,
        S_WAIT
    } t_state;

    // Kind of printer byte travelling down the emit pipeline
    typedef enum logic [1:0] {
        K_LINE,
        K_CR,
        K_UL,
        K_TERM
    } t_kind;

    typedef struct packed {
        logic  load;
        logic  exec_char;
        logic  end_line;
        logic  clear_line;
        logic  idx_clr;
        logic  idx_inc;
        logic  rd_idx;
        logic  rd_en;
        logic  issue;
        t_kind kind;
    } t_cmd;

    typedef struct packed {
        logic line_end;
        logic skip;
        logic ext_zero;
        logic ovs;
        logic idx_last;
        logic adv;
        logic b_busy;
    } t_stat;

endpackage

>>> src/ploc_in_if.sv
`timescale 1ns / 1ps

interface ploc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_file;

    modport source (output valid, char_code, end_of_file, input ready);
    modport sink (input valid, char_code, end_of_file, output ready);
endinterface

>>> src/ploc_out_if.sv
`timescale 1ns / 1ps

interface ploc_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] out_bytes;
    logic [3:0]  byte_count;
    logic        last_of_line;
    logic [15:0] page_total;

    modport source (output valid, out_bytes, byte_count, last_of_line, page_total, input ready);
    modport sink (input valid, out_bytes, byte_count, last_of_line, page_total, output ready);
endinterface

>>> src/ploc_ctrl.sv
`timescale 1ns / 1ps

module ploc_ctrl import ploc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.rd_en = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_stat.line_end ? S_END : S_CHAR;
                end
            end
            S_CHAR: begin
                o_cmd.exec_char = 1'b1;
                n_state         = S_IDLE;
            end
            S_END: begin
                o_cmd.end_line = 1'b1;
                o_cmd.idx_clr  = 1'b1;
                if (i_stat.skip) begin
                    // drop a blank line at page top
                    o_cmd.clear_line = 1'b1;
                    n_state          = S_IDLE;
                end else if (!i_stat.ext_zero) begin
                    n_state = S_LINE;
                end else begin
                    n_state = S_TERM;
                end
            end
            S_LINE: begin
                o_cmd.rd_idx = 1'b1;
                o_cmd.kind   = K_LINE;
                if (i_stat.adv) begin
                    o_cmd.issue = 1'b1;
                    o_cmd.rd_en = 1'b1;
                    if (i_stat.idx_last) begin
                        o_cmd.idx_clr = 1'b1;
                        n_state       = i_stat.ovs ? S_CR : S_TERM;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                    end
                end
            end
            S_CR: begin
                o_cmd.kind = K_CR;
                if (i_stat.adv) begin
                    o_cmd.issue = 1'b1;
                    n_state     = i_stat.ext_zero ? S_TERM : S_UL;
                end
            end
            S_UL: begin
                o_cmd.kind = K_UL;
                if (i_stat.adv) begin
                    o_cmd.issue = 1'b1;
                    if (i_stat.idx_last) begin
                        o_cmd.idx_clr = 1'b1;
                        n_state       = S_TERM;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                    end
                end
            end
            S_TERM: begin
                o_cmd.kind = K_TERM;
                if (i_stat.adv) begin
                    o_cmd.issue = 1'b1;
                    n_state     = S_WAIT;
                end
            end
            S_WAIT: begin
                // wait until the closing byte has left the pipeline
                if (!i_stat.b_busy) begin
                    o_cmd.clear_line = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> src/ploc_dp.sv
`timescale 1ns / 1ps

module ploc_dp import ploc_pkg::*; #(
    parameter int LINE_LENGTH = 132
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [7:0]  i_char_code,
    input  logic        i_end_of_file,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data,
    output logic [7:0]  o_lpp,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output logic [63:0] o_out_bytes,
    output logic [3:0]  o_out_count,
    output logic        o_out_last,
    output logic [15:0] o_page_total
);

    localparam int IW = $clog2(LINE_LENGTH);
    localparam int EW = $clog2(LINE_LENGTH + 1);
    localparam logic [15:0]   LL_COL = 16'(LINE_LENGTH);
    localparam logic [EW-1:0] LL_EXT = EW'(LINE_LENGTH);

    // Line store and per-column flags
    logic [7:0]             r_mem [LINE_LENGTH];
    logic [7:0]             r_rd_data;
    logic [LINE_LENGTH-1:0] r_vld;
    logic [LINE_LENGTH-1:0] r_ul;

    // Line and page state
    logic [7:0]    r_char;
    logic          r_eof;
    logic [15:0]   r_column, n_column;
    logic [EW-1:0] r_ext, n_ext;
    logic          r_ovs, n_ovs;
    logic [7:0]    r_lop, n_lop;
    logic [1:0]    r_blanks, n_blanks;
    logic [15:0]   r_page, n_page;
    logic [7:0]    r_lpp;
    logic          r_form;

    // Emit pipeline
    logic [IW-1:0] r_idx;
    logic          r_b_vld;
    t_kind         r_b_kind;
    logic [IW-1:0] r_b_idx;
    logic [55:0]   r_pack;
    logic [2:0]    r_pack_cnt;
    logic          r_out_valid;
    logic [63:0]   r_out_bytes;
    logic [3:0]    r_out_count;
    logic          r_out_last;
    logic [15:0]   r_out_page;

    logic          col_in;
    logic [IW-1:0] col_idx;
    logic [IW-1:0] rd_addr;
    logic [7:0]    cur;
    logic [16:0]   sum_p1;
    logic [16:0]   sum_tab;
    logic [15:0]   col_p1;
    logic [15:0]   col_tab;
    logic [15:0]   adv_to;
    logic          move;
    logic          track;
    logic [EW-1:0] ext_cand;
    logic          mem_we;
    logic          set_ul;
    logic          skip;
    logic          form;
    logic [15:0]   page_inc;
    logic [7:0]    b_byte;
    logic          b_done;
    logic          out_free;
    logic          adv;
    logic          push;
    logic [63:0]   word;

    // Column helpers
    assign col_in  = r_column < LL_COL;
    assign col_idx = col_in ? IW'(r_column) : '0;
    assign rd_addr = i_cmd.rd_idx ? r_idx : col_idx;
    assign cur     = r_vld[col_idx] ? r_rd_data : CH_SPACE;
    assign sum_p1  = {1'b0, r_column} + 17'd1;
    assign sum_tab = {1'b0, r_column | 16'h0007} + 17'd1;
    assign col_p1  = sum_p1[16] ? COL_MAX : sum_p1[15:0];
    assign col_tab = sum_tab[16] ? COL_MAX : sum_tab[15:0];

    // Line end decisions
    assign skip     = (r_lop == 8'd0) && (r_ext == '0) && (r_blanks < BLANK_LIMIT);
    assign form     = r_lop >= r_lpp;
    assign page_inc = (r_page == PAGE_MAX) ? r_page : r_page + 16'd1;

    // Decode the byte, handle line end
    always_comb begin
        move     = 1'b0;
        track    = 1'b0;
        adv_to   = col_p1;
        mem_we   = 1'b0;
        set_ul   = 1'b0;
        ext_cand = '0;
        n_column = r_column;
        n_ext    = r_ext;
        n_ovs    = r_ovs;
        n_lop    = r_lop;
        n_blanks = r_blanks;
        n_page   = r_page;

        case (r_char)
            CH_FF: begin
                n_lop = r_lpp;
            end
            CH_SPACE: begin
                move = 1'b1;
            end
            CH_TAB: begin
                move   = 1'b1;
                track  = 1'b1;
                adv_to = col_tab;
            end
            CH_CR: begin
                n_column = '0;
            end
            CH_BS: begin
                if (r_column != 16'd0) begin
                    n_column = r_column - 16'd1;
                end
            end
            CH_USCORE: begin
                move = 1'b1;
                if (col_in) begin
                    track = 1'b1;
                    if (cur != CH_SPACE) begin
                        set_ul = 1'b1;
                    end else begin
                        mem_we = 1'b1;
                    end
                end
            end
            default: begin
                if (r_char > CH_SPACE && col_in) begin
                    move   = 1'b1;
                    track  = 1'b1;
                    mem_we = 1'b1;
                    if (cur == CH_USCORE) begin
                        set_ul = 1'b1;
                    end
                end
            end
        endcase

        if (move) begin
            n_column = adv_to;
        end
        if (track) begin
            ext_cand = (adv_to >= LL_COL) ? LL_EXT : EW'(adv_to);
            if (ext_cand > r_ext) begin
                n_ext = ext_cand;
            end
        end
        if (set_ul) begin
            n_ovs = 1'b1;
        end

        // none of the commands below is ever active with exec_char
        if (!i_cmd.exec_char) begin
            n_column = r_column;
            n_ext    = r_ext;
            n_ovs    = r_ovs;
            n_lop    = r_lop;
        end

        if (i_cmd.end_line) begin
            if (skip) begin
                n_blanks = r_blanks + 2'd1;
            end else if (form) begin
                n_blanks = '0;
                n_lop    = '0;
                n_page   = page_inc;
            end else begin
                n_lop = r_lop + 8'd1;
            end
            // a page still open at end of file is counted; that only
            // happens on the newline path, where the counter is untouched
            if (r_eof) begin
                if (n_lop != 8'd0) begin
                    n_page = page_inc;
                end
                n_lop    = '0;
                n_blanks = '0;
            end
        end

        if (i_cmd.clear_line) begin
            n_column = '0;
            n_ext    = '0;
            n_ovs    = 1'b0;
        end
    end

    // Line store memory, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec_char && mem_we) begin
            r_mem[col_idx] <= r_char;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Column valid and underline flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_ul  <= '0;
        end else if (i_cmd.clear_line) begin
            r_vld <= '0;
            r_ul  <= '0;
        end else if (i_cmd.exec_char) begin
            if (mem_we) begin
                r_vld[col_idx] <= 1'b1;
            end
            if (set_ul) begin
                r_ul[col_idx] <= 1'b1;
            end
        end
    end

    // Line and page state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column <= '0;
            r_ext    <= '0;
            r_ovs    <= 1'b0;
            r_lop    <= '0;
            r_blanks <= '0;
            r_page   <= PAGE_RESET;
            r_lpp    <= LPP_RESET;
            r_form   <= 1'b0;
        end else begin
            r_column <= n_column;
            r_ext    <= n_ext;
            r_ovs    <= n_ovs;
            r_lop    <= n_lop;
            r_blanks <= n_blanks;
            r_page   <= n_page;
            if (i_cfg_we) begin
                r_lpp <= i_cfg_data;
            end
            if (i_cmd.end_line) begin
                r_form <= form;
            end
        end
    end

    // Capture the accepted item
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_char <= i_char_code;
            r_eof  <= i_end_of_file;
        end
    end

    // Byte at the packer input
    always_comb begin
        case (r_b_kind)
            K_LINE:  b_byte = r_vld[r_b_idx] ? r_rd_data : CH_SPACE;
            K_CR:    b_byte = CH_CR;
            K_UL:    b_byte = r_ul[r_b_idx] ? CH_USCORE : CH_SPACE;
            default: b_byte = r_form ? CH_FF : CH_LF;
        endcase
    end

    assign b_done   = (r_pack_cnt == 3'd7) || (r_b_kind == K_TERM);
    assign out_free = !r_out_valid || i_out_ready;
    assign adv      = !(r_b_vld && b_done && !out_free);
    assign push     = r_b_vld && adv;
    assign word     = {8'h00, r_pack} | (64'(b_byte) << {r_pack_cnt, 3'b000});

    // Advance the emit index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + IW'(1);
        end
    end

    // Byte stage, held while a full word cannot leave
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (adv) begin
            r_b_vld <= i_cmd.issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b_kind <= i_cmd.kind;
            r_b_idx  <= r_idx;
        end
    end

    // Pack bytes, eight to a word; a line's closing byte ends a word early
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pack     <= '0;
            r_pack_cnt <= '0;
        end else if (push) begin
            if (b_done) begin
                r_pack     <= '0;
                r_pack_cnt <= '0;
            end else begin
                r_pack     <= word[55:0];
                r_pack_cnt <= r_pack_cnt + 3'd1;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (push && b_done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push && b_done) begin
            r_out_bytes <= word;
            r_out_count <= {1'b0, r_pack_cnt} + 4'd1;
            r_out_last  <= (r_b_kind == K_TERM);
            r_out_page  <= r_page;
        end
    end

    // Status to the controller
    assign o_stat.line_end = i_end_of_file || (i_char_code == CH_LF);
    assign o_stat.skip     = skip;
    assign o_stat.ext_zero = (r_ext == '0);
    assign o_stat.ovs      = r_ovs;
    assign o_stat.idx_last = (EW'(r_idx) + EW'(1)) == r_ext;
    assign o_stat.adv      = adv;
    assign o_stat.b_busy   = r_b_vld;

    assign o_lpp        = r_lpp;
    assign o_out_valid  = r_out_valid;
    assign o_out_bytes  = r_out_bytes;
    assign o_out_count  = r_out_count;
    assign o_out_last   = r_out_last;
    assign o_page_total = r_out_page;

endmodule

>>> src/printer_line_overstrike_compositor_unit.sv
`timescale 1ns / 1ps
// Text byte: accepted, executed in the next cycle, only then is the input ready again.
// Line end: a decision state, then one printer byte per cycle unless the output stalls
// (extent, plus extent + 1 when overstruck, plus the LF/FF), then the pipeline drains.
// The line store's single read port, one byte a cycle, sets the line end time.
// Reset is synchronous, active low; column flags clear at once, no clearing pass.
module printer_line_overstrike_compositor_unit import ploc_pkg::*; #(
    parameter int LINE_LENGTH = 132
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    ploc_in_if.sink           i_in,
    ploc_out_if.source        o_out
);

    t_cmd       cmd;
    t_stat      stat;
    logic       cfg_hit;
    logic       cfg_we;
    logic [7:0] lpp;
    logic       in_acc;

    // Register decode
    assign cfg_hit = (paddr[APB_AW-1:2] == REG_LPP);
    assign cfg_we  = psel && penable && pwrite && cfg_hit;
    assign prdata  = cfg_hit ? {24'h000000, lpp} : 32'h00000000;
    assign pready  = 1'b1;

    ploc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ploc_dp #(
        .LINE_LENGTH (LINE_LENGTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_char_code   (i_in.char_code),
        .i_end_of_file (i_in.end_of_file),
        .i_cfg_we      (cfg_we),
        .i_cfg_data    (pwdata[7:0]),
        .o_lpp         (lpp),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_out_bytes   (o_out.out_bytes),
        .o_out_count   (o_out.byte_count),
        .o_out_last    (o_out.last_of_line),
        .o_page_total  (o_out.page_total)
    );

    assign in_acc = i_in.valid && i_in.ready;

    // An accepted item keeps the block busy for at least the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_in.ready)
        else $error("input ready right after an accepted item");

    // A result carries one to eight bytes
    a_byte_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.byte_count != 4'd0) && (o_out.byte_count <= 4'd8))
        else $error("result byte count out of range");

    // The page counter starts at one and saturates, so it never reads zero
    a_page_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.page_total != 16'd0))
        else $error("page total reads zero");

endmodule
